@@ rtl/core/fcl_pkg.sv @@
package fcl_pkg;

   // counts
   localparam int NUM_PLANES = 6;
   localparam int NUM_LODS   = 3;

   // field widths
   localparam int POS_W   = 20;
   localparam int NRM_W   = 14;
   localparam int OFS_W   = 22;
   localparam int MESH_W  = 16;
   localparam int DIST_W  = 20;
   localparam int CAM_W   = 3 * POS_W;

   // fixed point alignment of the plane offset and radius to Q.16
   localparam int FRAC_SHIFT = 12;

   // arithmetic widths
   localparam int PROD_W   = NRM_W + POS_W;
   localparam int DOT_W    = PROD_W + 4;
   localparam int DELTA_W  = POS_W + 1;
   localparam int SQ_W     = 2 * POS_W + 1;
   localparam int THR_SQ_W = 2 * DIST_W;
   localparam int DSQ_W    = 42;

   // csr port
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_LSB = 3;
   localparam int CSR_IDX_W  = 3;

   localparam logic [MESH_W-1:0] MESH_INVALID = '1;

   // register index map
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PLANE_LEFT   = 3'd0,
      REG_PLANE_RIGHT  = 3'd1,
      REG_PLANE_BOTTOM = 3'd2,
      REG_PLANE_TOP    = 3'd3,
      REG_PLANE_NEAR   = 3'd4,
      REG_PLANE_FAR    = 3'd5,
      REG_CAMERA       = 3'd6
   } reg_index_type;

   // plane register packing, nx in the low bits
   typedef struct packed {
      logic signed [OFS_W-1:0] w;
      logic signed [NRM_W-1:0] nz;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nx;
   } plane_type;

   // camera register packing, x in the low bits
   typedef struct packed {
      logic signed [POS_W-1:0] z;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] x;
   } camera_type;

endpackage

@@ rtl/core/frustum_cull_lod_select_unit.sv @@
// an accepted request passes stage 1, stage 2 and the response register in order
// throughput: one entity per cycle unless the response stalls, set by the plane
//   and distance multiply stage then the plane sum and threshold compare stage
// culled entities take the same slots and simply produce no response
// reset: synchronous, active high; clears pipeline valids, planes and camera to zero
module frustum_cull_lod_select_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [fcl_pkg::POS_W-1:0]       req_pos_x,
   input  logic signed [fcl_pkg::POS_W-1:0]       req_pos_y,
   input  logic signed [fcl_pkg::POS_W-1:0]       req_pos_z,
   input  logic        [fcl_pkg::POS_W-1:0]       req_bounding_radius,
   input  logic        [fcl_pkg::MESH_W-1:0]      req_base_mesh,
   input  logic        [fcl_pkg::MESH_W-1:0]      req_material,
   input  logic        [fcl_pkg::DIST_W-1:0]      req_lod1_distance,
   input  logic        [fcl_pkg::DIST_W-1:0]      req_lod2_distance,
   input  logic        [fcl_pkg::DIST_W-1:0]      req_lod3_distance,
   input  logic        [fcl_pkg::MESH_W-1:0]      req_lod1_mesh,
   input  logic        [fcl_pkg::MESH_W-1:0]      req_lod2_mesh,
   input  logic        [fcl_pkg::MESH_W-1:0]      req_lod3_mesh,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic        [fcl_pkg::MESH_W-1:0]      rsp_chosen_mesh,
   output logic        [fcl_pkg::MESH_W-1:0]      rsp_material_out,
   output logic        [fcl_pkg::DSQ_W-1:0]       rsp_distance_squared,
   // csr port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic        [fcl_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic        [fcl_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic        [fcl_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                   pready
);
   import fcl_pkg::*;

   // csr storage
   plane_type      plane_ff [NUM_PLANES];
   camera_type     camera_ff;
   reg_index_type  csr_idx;
   logic           csr_write;

   // pipeline handshake
   logic out_adv, s2_adv, s1_adv;

   // stage 1: captured request
   logic                     s1_valid_ff;
   logic signed [POS_W-1:0]  s1_pos_x_ff, s1_pos_y_ff, s1_pos_z_ff;
   logic        [POS_W-1:0]  s1_radius_ff;
   logic        [MESH_W-1:0] s1_base_ff, s1_mat_ff;
   logic        [DIST_W-1:0] s1_lod_dist_ff [NUM_LODS];
   logic        [MESH_W-1:0] s1_lod_mesh_ff [NUM_LODS];
   logic        [DIST_W-1:0] req_lod_dist [NUM_LODS];
   logic        [MESH_W-1:0] req_lod_mesh [NUM_LODS];

   // stage 2: products
   logic                       s2_valid_ff;
   logic        [POS_W-1:0]    s2_radius_ff;
   logic        [MESH_W-1:0]   s2_base_ff, s2_mat_ff;
   logic        [MESH_W-1:0]   s2_lod_mesh_ff [NUM_LODS];
   logic        [THR_SQ_W-1:0] s2_thr_sq_in [NUM_LODS];
   logic        [THR_SQ_W-1:0] s2_thr_sq_ff [NUM_LODS];
   logic signed [DELTA_W-1:0]  delta [3];
   logic signed [2*DELTA_W-1:0] delta_sq [3];
   logic        [SQ_W-1:0]     s2_sq_ff [3];
   logic        [NUM_PLANES-1:0] outside;

   // stage 3: response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MESH_W-1:0] rsp_mesh_ff, rsp_mesh_in;
   logic [MESH_W-1:0] rsp_mat_ff;
   logic [DSQ_W-1:0]  rsp_dsq_ff, rsp_dsq_in;

   // csr access decode
   assign pready    = 1'b1;
   assign csr_idx   = reg_index_type'(paddr[CSR_IDX_LSB +: CSR_IDX_W]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
         camera_ff <= '0;
      end else if (csr_write) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            if (csr_idx == reg_index_type'(i)) begin
               plane_ff[i] <= plane_type'(pwdata);
            end
         end
         if (csr_idx == REG_CAMERA) begin
            camera_ff <= camera_type'(pwdata[CAM_W-1:0]);
         end
      end
   end

   // csr read back
   always_comb begin
      unique case (csr_idx)
         REG_PLANE_LEFT:   prdata = plane_ff[0];
         REG_PLANE_RIGHT:  prdata = plane_ff[1];
         REG_PLANE_BOTTOM: prdata = plane_ff[2];
         REG_PLANE_TOP:    prdata = plane_ff[3];
         REG_PLANE_NEAR:   prdata = plane_ff[4];
         REG_PLANE_FAR:    prdata = plane_ff[5];
         REG_CAMERA:       prdata = CSR_DATA_W'(camera_ff);
         default:          prdata = '0;
      endcase
   end

   // each stage moves when the one after it is empty or moving
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || out_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;

   assign req_lod_dist[0] = req_lod1_distance;
   assign req_lod_dist[1] = req_lod2_distance;
   assign req_lod_dist[2] = req_lod3_distance;
   assign req_lod_mesh[0] = req_lod1_mesh;
   assign req_lod_mesh[1] = req_lod2_mesh;
   assign req_lod_mesh[2] = req_lod3_mesh;

   // stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_pos_x_ff  <= req_pos_x;
         s1_pos_y_ff  <= req_pos_y;
         s1_pos_z_ff  <= req_pos_z;
         s1_radius_ff <= req_bounding_radius;
         s1_base_ff   <= req_base_mesh;
         s1_mat_ff    <= req_material;
         for (int i = 0; i < NUM_LODS; i++) begin
            s1_lod_dist_ff[i] <= req_lod_dist[i];
            s1_lod_mesh_ff[i] <= req_lod_mesh[i];
         end
      end
   end

   // plane tests, products registered inside each unit
   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      fcl_plane_test u_plane (
         .clock   (clock),
         .load    (s2_adv),
         .plane   (plane_ff[p]),
         .pos_x   (s1_pos_x_ff),
         .pos_y   (s1_pos_y_ff),
         .pos_z   (s1_pos_z_ff),
         .radius  (s2_radius_ff),
         .outside (outside[p])
      );
   end

   // camera deltas and their squares
   assign delta[0] = DELTA_W'(s1_pos_x_ff) - DELTA_W'(camera_ff.x);
   assign delta[1] = DELTA_W'(s1_pos_y_ff) - DELTA_W'(camera_ff.y);
   assign delta[2] = DELTA_W'(s1_pos_z_ff) - DELTA_W'(camera_ff.z);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         delta_sq[a] = delta[a] * delta[a];
      end
      for (int i = 0; i < NUM_LODS; i++) begin
         s2_thr_sq_in[i] = s1_lod_dist_ff[i] * s1_lod_dist_ff[i];
      end
   end

   // stage 2 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_radius_ff <= s1_radius_ff;
         s2_base_ff   <= s1_base_ff;
         s2_mat_ff    <= s1_mat_ff;
         for (int a = 0; a < 3; a++) begin
            s2_sq_ff[a] <= delta_sq[a][SQ_W-1:0];
         end
         for (int i = 0; i < NUM_LODS; i++) begin
            s2_lod_mesh_ff[i] <= s1_lod_mesh_ff[i];
            s2_thr_sq_ff[i]   <= s2_thr_sq_in[i];
         end
      end
   end

   // distance sum, detail level pick, cull decision
   always_comb begin
      rsp_dsq_in  = DSQ_W'(s2_sq_ff[0]) + DSQ_W'(s2_sq_ff[1]) + DSQ_W'(s2_sq_ff[2]);
      rsp_mesh_in = s2_base_ff;
      // higher levels overwrite lower ones, so level 3 has priority
      for (int i = 0; i < NUM_LODS; i++) begin
         if (s2_lod_mesh_ff[i] != MESH_INVALID &&
             rsp_dsq_in > DSQ_W'(s2_thr_sq_ff[i])) begin
            rsp_mesh_in = s2_lod_mesh_ff[i];
         end
      end
      rsp_valid_in = s2_valid_ff && !(|outside);
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_mesh_ff <= rsp_mesh_in;
         rsp_mat_ff  <= s2_mat_ff;
         rsp_dsq_ff  <= rsp_dsq_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_chosen_mesh      = rsp_mesh_ff;
   assign rsp_material_out     = rsp_mat_ff;
   assign rsp_distance_squared = rsp_dsq_ff;

   // an accepted transaction always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted request did not reach stage 1");

   // an empty front stage never refuses a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("request refused with stage 1 empty");

   // a new response only comes from an item held in stage 2
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(out_adv) && !$past(reset)) |-> $past(s2_valid_ff))
      else $error("response without a stage 2 item");

endmodule

@@ rtl/core/fcl_plane_test.sv @@
module fcl_plane_test (
   input  logic                               clock,
   input  logic                               load,
   input  fcl_pkg::plane_type                 plane,
   input  logic signed [fcl_pkg::POS_W-1:0]   pos_x,
   input  logic signed [fcl_pkg::POS_W-1:0]   pos_y,
   input  logic signed [fcl_pkg::POS_W-1:0]   pos_z,
   input  logic        [fcl_pkg::POS_W-1:0]   radius,
   output logic                               outside
);
   import fcl_pkg::*;

   logic signed [PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [DOT_W-1:0]  dot;

   // normal times position, one product per axis
   assign prod_x_in = plane.nx * pos_x;
   assign prod_y_in = plane.ny * pos_y;
   assign prod_z_in = plane.nz * pos_z;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
   end

   // d + radius in Q.16, sphere is outside when negative
   assign dot = DOT_W'(prod_x_ff) + DOT_W'(prod_y_ff) + DOT_W'(prod_z_ff)
              + DOT_W'($signed({plane.w, {FRAC_SHIFT{1'b0}}}))
              + $signed(DOT_W'({radius, {FRAC_SHIFT{1'b0}}}));

   assign outside = dot[DOT_W-1];

endmodule
